>>> src/assert_macros.svh
// Assertion helpers for the RTL file that checks itself.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge outside reset.
`define RCLT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define RCLT_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/rclt_pkg.sv
`timescale 1ns / 1ps

package rclt_pkg;

    // Geometry of the tag store.
    localparam int MAX_WAYS   = 16;
    localparam int ROW_BITS   = 16;
    localparam int WAY_BITS   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int STAMP_BITS = 64;
    localparam int CFG_BITS   = 5;
    localparam int OP_BITS    = 2;

    typedef logic [ROW_BITS-1:0]   row_t;
    typedef logic [WAY_BITS-1:0]   way_idx_t;
    typedef logic [STAMP_BITS-1:0] stamp_t;
    typedef logic [CFG_BITS-1:0]   cfg_t;
    typedef logic [OP_BITS-1:0]    op_t;

    // Operation codes; the fourth code does nothing but answer.
    localparam op_t OP_ACCESS = 2'd0;
    localparam op_t OP_PROBE  = 2'd1;
    localparam op_t OP_FLUSH  = 2'd2;

    localparam cfg_t WAYS_RESET = cfg_t'(16);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    // Write request from the sequencer to the way store.
    typedef struct packed {
        logic     en;
        logic     flush;
        logic     alloc;
        way_idx_t idx;
        row_t     row;
    } wr_req_t;

    // What the scan unit has found so far.
    typedef struct packed {
        logic     match;
        logic     found;
        way_idx_t way;
    } scan_res_t;

    // Index of the last way in use, with zero read as one and the top clipped.
    function automatic way_idx_t last_way(input cfg_t ways);
        way_idx_t res;
        if (ways == '0)
        begin
            res = '0;
        end
        else if (int'(ways) > MAX_WAYS)
        begin
            res = way_idx_t'(MAX_WAYS - 1);
        end
        else
        begin
            res = way_idx_t'(ways - cfg_t'(1));
        end
        return res;
    endfunction

endpackage

>>> src/rclt_ifs.sv
`timescale 1ns / 1ps

// Request channel: one lookup, probe or flush per item.
interface rclt_req_if;
    logic                 valid;
    logic                 ready;
    rclt_pkg::op_t        operation;
    rclt_pkg::row_t       requested_row;

    modport source (output valid, output operation, output requested_row, input ready);
    modport sink (input valid, input operation, input requested_row, output ready);
endinterface

// Response channel: one result per request item.
interface rclt_rsp_if;
    logic                 valid;
    logic                 ready;
    logic                 hit;
    rclt_pkg::way_idx_t   way_index;

    modport source (output valid, output hit, output way_index, input ready);
    modport sink (input valid, input hit, input way_index, output ready);
endinterface

>>> src/rclt_way_store.sv
`timescale 1ns / 1ps

module rclt_way_store (
    input  logic                clk,
    input  logic                rst_n,
    input  rclt_pkg::way_idx_t  rd_idx,
    output logic                rd_valid,
    output rclt_pkg::row_t      rd_tag,
    output rclt_pkg::stamp_t    rd_stamp,
    input  rclt_pkg::wr_req_t   wr
);

    logic [rclt_pkg::MAX_WAYS-1:0] valid_reg;
    rclt_pkg::row_t                tag_reg   [rclt_pkg::MAX_WAYS];
    rclt_pkg::stamp_t              stamp_reg [rclt_pkg::MAX_WAYS];
    rclt_pkg::stamp_t              use_count_reg;

    // Valid bits and the global use counter are control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            use_count_reg <= rclt_pkg::stamp_t'(1);
        end
        else
        begin
            if (wr.flush)
            begin
                valid_reg <= '0;
            end
            else if (wr.en && wr.alloc)
            begin
                valid_reg[wr.idx] <= 1'b1;
            end
            if (wr.en)
            begin
                use_count_reg <= use_count_reg + rclt_pkg::stamp_t'(1);
            end
        end
    end

    // Tags are only used behind a set valid bit; stamps are compared for every way scanned.
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            stamp_reg[wr.idx] <= use_count_reg;
            if (wr.alloc)
            begin
                tag_reg[wr.idx] <= wr.row;
            end
        end
    end

    // The scan reads one way at a time.
    assign rd_valid = valid_reg[rd_idx];
    assign rd_tag   = tag_reg[rd_idx];
    assign rd_stamp = stamp_reg[rd_idx];

endmodule

>>> src/rclt_scan.sv
`timescale 1ns / 1ps

module rclt_scan (
    input  logic                clk,
    input  logic                step,
    input  rclt_pkg::way_idx_t  idx,
    input  rclt_pkg::row_t      row,
    input  logic                rd_valid,
    input  rclt_pkg::row_t      rd_tag,
    input  rclt_pkg::stamp_t    rd_stamp,
    output rclt_pkg::scan_res_t res
);

    logic               found_reg;
    rclt_pkg::way_idx_t found_idx_reg;
    logic               empty_seen_reg;
    rclt_pkg::way_idx_t empty_idx_reg;
    rclt_pkg::way_idx_t best_idx_reg;
    rclt_pkg::stamp_t   best_stamp_reg;

    logic match;
    logic first;
    logic older;

    // The shared compare unit: one tag compare and one stamp compare per way.
    assign first = (idx == '0);
    assign match = rd_valid && (rd_tag == row);
    assign older = rd_stamp < best_stamp_reg;

    // Running record of the first hit, the first empty way and the oldest way.
    // Every record restarts when the scan is at way zero.
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            found_reg     <= match || (!first && found_reg);
            found_idx_reg <= idx;
            if (!rd_valid && (first || !empty_seen_reg))
            begin
                empty_seen_reg <= 1'b1;
                empty_idx_reg  <= idx;
            end
            else if (first)
            begin
                empty_seen_reg <= 1'b0;
            end
            if (first || older)
            begin
                best_idx_reg   <= idx;
                best_stamp_reg <= rd_stamp;
            end
        end
    end

    // A hit wins, then the first empty way, then the oldest stamp.
    always_comb
    begin
        res.match = match;
        res.found = found_reg;
        if (found_reg)
        begin
            res.way = found_idx_reg;
        end
        else if (empty_seen_reg)
        begin
            res.way = empty_idx_reg;
        end
        else
        begin
            res.way = best_idx_reg;
        end
    end

endmodule

>>> src/rclt_seq.sv
`timescale 1ns / 1ps

module rclt_seq (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  rclt_pkg::op_t       req_op,
    input  rclt_pkg::row_t      req_row,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output logic                rsp_hit,
    output rclt_pkg::way_idx_t  rsp_way,
    input  rclt_pkg::way_idx_t  last_idx,
    output logic                scan_step,
    output rclt_pkg::way_idx_t  scan_idx,
    output rclt_pkg::row_t      row,
    input  rclt_pkg::scan_res_t scan_res,
    output rclt_pkg::wr_req_t   wr
);

    rclt_pkg::state_t   state_reg, state_next;
    rclt_pkg::way_idx_t idx_reg, idx_next;
    logic               out_valid_reg, out_valid_next;
    rclt_pkg::op_t      op_reg, op_next;
    rclt_pkg::row_t     row_reg, row_next;
    logic               hit_reg, hit_next;
    rclt_pkg::way_idx_t way_reg, way_next;
    logic               load;

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rclt_pkg::ST_IDLE;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Item and result payload.
    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        row_reg <= row_next;
        hit_reg <= hit_next;
        way_reg <= way_next;
    end

    // Sequencer: accept, scan on access/probe, write on access/flush, then answer.
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        op_next    = op_reg;
        row_next   = row_reg;
        hit_next   = hit_reg;
        way_next   = way_reg;
        load       = 1'b0;
        scan_step  = 1'b0;
        wr         = '0;
        wr.idx     = scan_res.way;
        wr.row     = row_reg;

        case (state_reg)
            rclt_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    op_next  = req_op;
                    row_next = req_row;
                    idx_next = '0;
                    if (req_op == rclt_pkg::OP_ACCESS || req_op == rclt_pkg::OP_PROBE)
                    begin
                        state_next = rclt_pkg::ST_SCAN;
                    end
                    else
                    begin
                        state_next = rclt_pkg::ST_FINISH;
                    end
                end
            end
            rclt_pkg::ST_SCAN:
            begin
                scan_step = 1'b1;
                if (scan_res.match || idx_reg == last_idx)
                begin
                    state_next = rclt_pkg::ST_FINISH;
                end
                else
                begin
                    idx_next = idx_reg + rclt_pkg::way_idx_t'(1);
                end
            end
            rclt_pkg::ST_FINISH:
            begin
                if (!out_valid_reg || rsp_ready)
                begin
                    load       = 1'b1;
                    state_next = rclt_pkg::ST_IDLE;
                    hit_next   = 1'b0;
                    way_next   = '0;
                    if (op_reg == rclt_pkg::OP_ACCESS)
                    begin
                        wr.en    = 1'b1;
                        wr.alloc = !scan_res.found;
                        hit_next = scan_res.found;
                        way_next = scan_res.way;
                    end
                    else if (op_reg == rclt_pkg::OP_PROBE)
                    begin
                        if (scan_res.found)
                        begin
                            hit_next = 1'b1;
                            way_next = scan_res.way;
                        end
                    end
                    else if (op_reg == rclt_pkg::OP_FLUSH)
                    begin
                        wr.flush = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = rclt_pkg::ST_IDLE;
            end
        endcase

        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign req_ready = (state_reg == rclt_pkg::ST_IDLE);
    assign rsp_valid = out_valid_reg;
    assign rsp_hit   = hit_reg;
    assign rsp_way   = way_reg;
    assign scan_idx  = idx_reg;
    assign row       = row_reg;

endmodule

>>> src/row_cache_lru_tag_lookup_unit.sv
`timescale 1ns / 1ps
// Row cache tag lookup: a fully associative store of source-row tags with
// least recently used replacement by 64-bit use stamps.
// req carries an item with an operation and a row number: access looks the
// row up and allocates on a miss, probe only looks up, flush empties all ways.
// rsp returns one item per request: hit and the way that holds the row.
// cfg_wr_en with cfg_wr_data sets the number of ways in use (0 reads as 1,
// values above 16 read as 16); write it only while the block is idle.
// An access or probe scans the ways in use one per cycle through a
// single tag and stamp compare unit, stopping early on a hit, then writes back
// and loads the result into its output register in the finish state.
// A flush or the unused code skips the scan. A new item is accepted once the
// previous one has been written back, even while its result still waits.
// When rsp is stalled the result holds in its output register, and the next
// item may finish its scan but waits before write-back until the slot frees.
// Reset empties every way, sets the use counter to one and the way count to
// 16; it needs no clearing pass.
`include "assert_macros.svh"

module row_cache_lru_tag_lookup_unit (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  rclt_pkg::cfg_t       cfg_wr_data,
    rclt_req_if.sink             req,
    rclt_rsp_if.source           rsp
);

    rclt_pkg::cfg_t      ways_reg;
    rclt_pkg::way_idx_t  last_idx;
    logic                scan_step;
    rclt_pkg::way_idx_t  scan_idx;
    rclt_pkg::row_t      row;
    rclt_pkg::scan_res_t scan_res;
    rclt_pkg::wr_req_t   wr;
    logic                rd_valid;
    rclt_pkg::row_t      rd_tag;
    rclt_pkg::stamp_t    rd_stamp;

    // Way count register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ways_reg <= rclt_pkg::WAYS_RESET;
        end
        else if (cfg_wr_en)
        begin
            ways_reg <= cfg_wr_data;
        end
    end

    assign last_idx = rclt_pkg::last_way(ways_reg);

    rclt_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .req_op    (req.operation),
        .req_row   (req.requested_row),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .rsp_hit   (rsp.hit),
        .rsp_way   (rsp.way_index),
        .last_idx  (last_idx),
        .scan_step (scan_step),
        .scan_idx  (scan_idx),
        .row       (row),
        .scan_res  (scan_res),
        .wr        (wr)
    );

    rclt_scan u_scan (
        .clk      (clk),
        .step     (scan_step),
        .idx      (scan_idx),
        .row      (row),
        .rd_valid (rd_valid),
        .rd_tag   (rd_tag),
        .rd_stamp (rd_stamp),
        .res      (scan_res)
    );

    rclt_way_store u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_idx   (scan_idx),
        .rd_valid (rd_valid),
        .rd_tag   (rd_tag),
        .rd_stamp (rd_stamp),
        .wr       (wr)
    );

    // An accepted item keeps the block busy for at least the next cycle.
    `RCLT_ASSERT(a_busy_after_accept, req.valid && req.ready |=> !req.ready, "item accepted while busy")
    // A result never names a way outside those in use.
    `RCLT_ASSERT(a_way_in_range, rsp.valid |-> rsp.way_index <= last_idx, "way outside range")
    // The store is written only when the sequencer is not taking a new item.
    `RCLT_ASSERT(a_write_not_idle, (wr.en || wr.flush) |-> !req.ready, "write while idle")
    // No result is shown in the cycle after reset has been seen held.
    `RCLT_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !rsp.valid, "result after reset")

endmodule
